[sv/tce_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tce_pkg: shared types and helpers for the tumour clone Euler stepper
// Formats, register indices and saturating fixed-point helpers.
// ----------------------------------------------------------------------------
package tce_pkg;

  localparam int unsigned PopW   = 48;
  localparam int unsigned StepW  = 32;
  localparam int unsigned CfgW   = 64;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [PopW-1:0]    PopMax  = '1;
  localparam logic signed [63:0] SatLim  = 64'sh2000_0000_0000_0000;

  // floor(x / 100) = (x * Div100Mul) >> Div100Sh for every x below 2^62
  localparam logic [63:0]        Div100Mul = 64'h51EB_851E_B851_EB86;
  localparam int unsigned        Div100Sh  = 69;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GROWTH,
    CFG_CROSS,
    CFG_KILL,
    CFG_TURN,
    CFG_SAT,
    CFG_CUT,
    CFG_DELAY,
    CFG_END
  } cfg_idx_e;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_e;

  function automatic logic signed [63:0] sx32(input logic [31:0] x);
    return {{32{x[31]}}, x};
  endfunction

  function automatic logic signed [63:0] clamp61(input logic signed [63:0] v);
    if (v > SatLim) return SatLim;
    if (v < -SatLim) return -SatLim;
    return v;
  endfunction

  function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    return clamp61(a + b);
  endfunction

  function automatic logic [63:0] magn(input logic signed [63:0] v);
    logic signed [63:0] n;
    n = -v;
    return v[63] ? $unsigned(n) : $unsigned(v);
  endfunction

  function automatic logic [PopW-1:0] advance(input logic [PopW-1:0] pop,
                                              input logic signed [63:0] inc);
    logic signed [63:0] v;
    v = $signed({16'b0, pop}) + inc;
    if (v < 0) return '0;
    if (v > $signed({16'b0, PopMax})) return PopMax;
    return v[PopW-1:0];
  endfunction

endpackage
`default_nettype wire

[sv/tumor_clone_euler_step.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tumor_clone_euler_step: forward Euler stepper for two subclones and T-cells
// Sequenced datapath around a shared 64x16 multiplier, a bit-serial square root
// and a bit-serial divider for the recruitment quotient.
// ----------------------------------------------------------------------------
// A load item goes through the emit state to the result register. A step item
// runs two bit-serial square roots, then products on the shared 64x16
// multiplier (each population increment is a reciprocal product for the
// division by 100); the T-cell products run only once the T-cell population
// moves, and a restoring divide for the recruitment quotient runs only when
// its denominator is nonzero. The commit and emit states follow. The input
// side stalls while an item is at work and takes the next item in the cycle
// after the result register loads; a finished result sits in the output
// register and may wait there while the next item is taken.
module tumor_clone_euler_step import tce_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               op_i,
  input  logic [PopW-1:0]    start_c1_i,
  input  logic [PopW-1:0]    start_c11_i,
  input  logic [PopW-1:0]    start_tcells_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [PopW-1:0]    size_c1_o,
  output logic [PopW-1:0]    size_c11_o,
  output logic [PopW-1:0]    size_tcells_o,
  output logic [StepW-1:0]   step_number_o,
  output logic               final_res_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_SQRT, S_MUL, S_MWB, S_DLD, S_DIV, S_DWB, S_FIN, S_EMIT
  } state_e;

  typedef enum logic [3:0] {
    M_ROOT, M_P1, M_P2, M_CT, M_P3, M_P4, M_P5,
    M_ST, M_P6, M_REC, M_P7, M_P8, M_ADV, M_CUT1, M_CUT11
  } mop_e;

  typedef enum logic [1:0] {
    DK_REC, DK_C1, DK_C11, DK_T
  } dk_e;

  state_e state_q;
  mop_e   mop_q;
  dk_e    dk_q;

  logic [CfgW-1:0]  growth_q, cross_q, kill_q, turn_q, satfl_q, cut_q;
  logic [StepW-1:0] delay_q, end_q, step_q;
  logic [PopW-1:0]  pop_c1_q, pop_c11_q, pop_t_q, n1_q, n11_q, nt_q;

  logic [63:0]  x_q, r_q, sbit_q;
  logic [4:0]   qcnt_q;
  logic         sq_sel_q;
  logic [31:0]  s1_q, s11_q;

  logic [127:0] acc_q;
  logic [1:0]   mcnt_q;
  logic signed [63:0] root_q, ct_q, st_q, ratio_q, d1_q, d11_q, dt_q;

  logic [61:0]  dvd_q;
  logic [40:0]  dvs_q, rem_q;
  logic [5:0]   dcnt_q;

  logic               out_valid_q, final_q;
  logic [PopW-1:0]    out_c1_q, out_c11_q, out_t_q;
  logic [StepW-1:0]   out_step_q;

  logic signed [63:0] g1, g11, cm, ck, cc, ca, cf, cb, cl, fracc, den;
  logic [31:0]        floorv, rawcut;
  logic               tact;

  assign g1     = sx32(growth_q[63:32]);
  assign g11    = sx32(growth_q[31:0]);
  assign cm     = sx32(cross_q[63:32]);
  assign ck     = sx32(cross_q[31:0]);
  assign cc     = sx32(kill_q[63:32]);
  assign ca     = sx32(kill_q[31:0]);
  assign cf     = sx32(turn_q[63:32]);
  assign cb     = sx32(turn_q[31:0]);
  assign cl     = sx32(satfl_q[63:32]);
  assign floorv = satfl_q[31:0];
  assign rawcut = cut_q[63:32];
  assign fracc  = sx32(cut_q[31:0]);
  assign tact   = step_q >= delay_q;
  assign den    = cl + $signed({24'b0, s1_q, 8'b0});

  // square root recurrence
  logic [63:0] rb, r_nxt;
  logic        sq_ge;
  assign rb    = r_q + sbit_q;
  assign sq_ge = x_q >= rb;
  assign r_nxt = sq_ge ? ((r_q >> 1) + sbit_q) : (r_q >> 1);

  // population increment selection
  logic signed [63:0] adv_d;
  logic [PopW-1:0]    adv_pop;
  logic [63:0]        adv_mag, adv_num;

  always_comb begin
    adv_d   = d1_q;
    adv_pop = pop_c1_q;
    case (dk_q)
      DK_C11:  begin adv_d = d11_q; adv_pop = pop_c11_q; end
      DK_T:    begin adv_d = dt_q; adv_pop = pop_t_q; end
      default: ;
    endcase
  end

  assign adv_mag = magn(adv_d);
  assign adv_num = {2'b0, adv_mag[61:0]} + (adv_d[63] ? 64'd99 : 64'd0);

  // multiplier operands
  logic signed [63:0] opa, opb;
  logic               sh16, sh69;
  logic [PopW:0]      cut_sum;
  assign cut_sum = {1'b0, n1_q} + {1'b0, n11_q};

  always_comb begin
    opa  = '0;
    opb  = '0;
    sh16 = 1'b0;
    sh69 = 1'b0;
    case (mop_q)
      M_ROOT:  begin opa = {32'b0, s1_q}; opb = {32'b0, s11_q}; sh16 = 1'b1; end
      M_P1:    begin opa = g1; opb = {16'b0, pop_c1_q}; end
      M_P2:    begin opa = ck; opb = root_q; end
      M_CT:    begin opa = {16'b0, pop_c1_q}; opb = {16'b0, pop_t_q}; sh16 = 1'b1; end
      M_P3:    begin opa = cc; opb = ct_q; end
      M_P4:    begin opa = g11; opb = {16'b0, pop_c11_q}; end
      M_P5:    begin opa = cm; opb = root_q; end
      M_ST:    begin opa = {32'b0, s1_q}; opb = {16'b0, pop_t_q}; sh16 = 1'b1; end
      M_P6:    begin opa = {32'b0, floorv}; opb = cf; end
      M_REC:   begin opa = ratio_q; opb = st_q; end
      M_P7:    begin opa = cb; opb = st_q; end
      M_P8:    begin opa = cf; opb = {16'b0, pop_t_q}; end
      M_ADV:   begin opa = $signed(adv_num); opb = $signed(Div100Mul); sh69 = 1'b1; end
      M_CUT1:  begin opa = fracc; opb = {15'b0, cut_sum}; end
      M_CUT11: begin opa = fracc; opb = {15'b0, cut_sum}; end
      default: ;
    endcase
  end

  logic [63:0]  mag_a, mag_b, mres_mag;
  logic [15:0]  chunk;
  logic [79:0]  part;
  logic [127:0] shf;
  logic         mneg;
  logic signed [63:0] mres, mres_n;

  assign mag_a    = magn(opa);
  assign mag_b    = magn(opb);
  assign mneg     = opa[63] ^ opb[63];
  assign chunk    = mag_b[{mcnt_q, 4'b0000} +: 16];
  assign part     = mag_a * chunk;
  assign shf      = sh69 ? (acc_q >> Div100Sh) :
                    (sh16 ? (acc_q >> 16) : (acc_q >> 24));
  assign mres_mag = (shf > {64'b0, SatLim}) ? SatLim : shf[63:0];
  assign mres     = mneg ? -$signed(mres_mag) : $signed(mres_mag);
  assign mres_n   = -mres;

  logic signed [63:0] inc;
  logic [PopW-1:0]    n_new;
  assign inc   = adv_d[63] ? mres_n : mres;
  assign n_new = advance(adv_pop, inc);

  logic cut_hit1, cut_hit11, frac_ok;
  assign frac_ok   = (cut_sum != '0) && !fracc[63];
  assign cut_hit1  = ({16'b0, n1_q} <= {32'b0, rawcut}) ||
                     (frac_ok && ($signed({16'b0, n1_q}) <= mres));
  assign cut_hit11 = ({16'b0, n11_q} <= {32'b0, rawcut}) ||
                     (frac_ok && ($signed({16'b0, n11_q}) <= mres));

  // divider
  logic signed [63:0] q64, ratio_n;
  logic [63:0]        a_mag, den_mag;
  logic [61:0]        div_num;
  logic [40:0]        div_den, rem_sub;
  logic [41:0]        trial, trial_sub;
  logic               div_ge;

  assign a_mag     = magn(ca);
  assign den_mag   = magn(den);
  assign div_num   = {6'b0, a_mag[31:0], 24'b0};
  assign div_den   = den_mag[40:0];
  assign trial     = {rem_q, dvd_q[61]};
  assign div_ge    = trial >= {1'b0, dvs_q};
  assign trial_sub = trial - {1'b0, dvs_q};
  assign rem_sub   = div_ge ? trial_sub[40:0] : trial[40:0];
  assign q64       = $signed({2'b0, dvd_q});
  assign ratio_n   = -q64;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mop_q       <= M_ROOT;
      dk_q        <= DK_REC;
      growth_q    <= '0;
      cross_q     <= '0;
      kill_q      <= '0;
      turn_q      <= '0;
      satfl_q     <= '0;
      cut_q       <= '0;
      delay_q     <= '0;
      end_q       <= '0;
      step_q      <= '0;
      pop_c1_q    <= '0;
      pop_c11_q   <= '0;
      pop_t_q     <= '0;
      n1_q        <= '0;
      n11_q       <= '0;
      nt_q        <= '0;
      x_q         <= '0;
      r_q         <= '0;
      sbit_q      <= '0;
      qcnt_q      <= '0;
      sq_sel_q    <= 1'b0;
      s1_q        <= '0;
      s11_q       <= '0;
      acc_q       <= '0;
      mcnt_q      <= '0;
      root_q      <= '0;
      ct_q        <= '0;
      st_q        <= '0;
      ratio_q     <= '0;
      d1_q        <= '0;
      d11_q       <= '0;
      dt_q        <= '0;
      dvd_q       <= '0;
      dvs_q       <= '0;
      rem_q       <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
      final_q     <= 1'b0;
      out_c1_q    <= '0;
      out_c11_q   <= '0;
      out_t_q     <= '0;
      out_step_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_GROWTH: growth_q <= cfg_data_i;
          CFG_CROSS:  cross_q  <= cfg_data_i;
          CFG_KILL:   kill_q   <= cfg_data_i;
          CFG_TURN:   turn_q   <= cfg_data_i;
          CFG_SAT:    satfl_q  <= cfg_data_i;
          CFG_CUT:    cut_q    <= cfg_data_i;
          CFG_DELAY:  delay_q  <= cfg_data_i[StepW-1:0];
          CFG_END:    end_q    <= cfg_data_i[StepW-1:0];
          default: ;
        endcase
      end

      if (out_valid_q && !out_stall_i && state_q != S_EMIT) out_valid_q <= 1'b0;

      if (state_q != S_MUL) begin
        acc_q  <= '0;
        mcnt_q <= '0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (op_e'(op_i) == OP_LOAD) begin
              pop_c1_q  <= start_c1_i;
              pop_c11_q <= start_c11_i;
              pop_t_q   <= start_tcells_i;
              step_q    <= '0;
              state_q   <= S_EMIT;
            end else begin
              x_q      <= {pop_c1_q, 16'b0};
              r_q      <= '0;
              sbit_q   <= 64'h4000_0000_0000_0000;
              qcnt_q   <= '0;
              sq_sel_q <= 1'b0;
              state_q  <= S_SQRT;
            end
          end
        end
        S_SQRT: begin
          qcnt_q <= qcnt_q + 5'd1;
          if (qcnt_q == 5'd31 && !sq_sel_q) begin
            s1_q     <= r_nxt[31:0];
            x_q      <= {pop_c11_q, 16'b0};
            r_q      <= '0;
            sbit_q   <= 64'h4000_0000_0000_0000;
            sq_sel_q <= 1'b1;
          end else begin
            if (sq_ge) x_q <= x_q - rb;
            r_q    <= r_nxt;
            sbit_q <= sbit_q >> 2;
            if (qcnt_q == 5'd31) begin
              s11_q   <= r_nxt[31:0];
              mop_q   <= M_ROOT;
              state_q <= S_MUL;
            end
          end
        end
        S_MUL: begin
          acc_q  <= acc_q + ({48'b0, part} << {mcnt_q, 4'b0000});
          mcnt_q <= mcnt_q + 2'd1;
          if (mcnt_q == 2'd3) state_q <= S_MWB;
        end
        S_MWB: begin
          case (mop_q)
            M_ROOT: begin root_q <= mres; mop_q <= M_P1; state_q <= S_MUL; end
            M_P1:   begin d1_q <= mres; mop_q <= M_P2; state_q <= S_MUL; end
            M_P2:   begin d1_q <= sadd(d1_q, mres); mop_q <= M_CT; state_q <= S_MUL; end
            M_CT:   begin ct_q <= mres; mop_q <= M_P3; state_q <= S_MUL; end
            M_P3:   begin d1_q <= sadd(d1_q, mres_n); mop_q <= M_P4; state_q <= S_MUL; end
            M_P4:   begin d11_q <= mres; mop_q <= M_P5; state_q <= S_MUL; end
            M_P5: begin
              d11_q   <= sadd(d11_q, mres);
              state_q <= S_MUL;
              if (tact) begin
                mop_q <= M_ST;
              end else begin
                dk_q  <= DK_C1;
                mop_q <= M_ADV;
              end
            end
            M_ST:   begin st_q <= mres; mop_q <= M_P6; state_q <= S_MUL; end
            M_P6: begin
              dt_q <= mres;
              if (den != '0) begin
                dk_q    <= DK_REC;
                state_q <= S_DLD;
              end else begin
                mop_q   <= M_P7;
                state_q <= S_MUL;
              end
            end
            M_REC:  begin dt_q <= sadd(dt_q, mres); mop_q <= M_P7; state_q <= S_MUL; end
            M_P7:   begin dt_q <= sadd(dt_q, mres_n); mop_q <= M_P8; state_q <= S_MUL; end
            M_P8: begin
              dt_q    <= sadd(dt_q, mres_n);
              dk_q    <= DK_C1;
              mop_q   <= M_ADV;
              state_q <= S_MUL;
            end
            M_ADV: begin
              state_q <= S_MUL;
              case (dk_q)
                DK_C1: begin
                  n1_q <= n_new;
                  dk_q <= DK_C11;
                end
                DK_C11: begin
                  n11_q <= n_new;
                  if (tact) begin
                    dk_q <= DK_T;
                  end else begin
                    nt_q  <= pop_t_q;
                    mop_q <= M_CUT1;
                  end
                end
                DK_T: begin
                  nt_q  <= n_new;
                  mop_q <= M_CUT1;
                end
                default: mop_q <= M_CUT1;
              endcase
            end
            M_CUT1: begin
              if (cut_hit1) n1_q <= '0;
              mop_q   <= M_CUT11;
              state_q <= S_MUL;
            end
            M_CUT11: begin
              if (cut_hit11) n11_q <= '0;
              state_q <= S_FIN;
            end
            default: state_q <= S_IDLE;
          endcase
        end
        S_DLD: begin
          dvd_q   <= div_num;
          dvs_q   <= div_den;
          rem_q   <= '0;
          dcnt_q  <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          rem_q  <= rem_sub;
          dvd_q  <= {dvd_q[60:0], div_ge};
          dcnt_q <= dcnt_q + 6'd1;
          if (dcnt_q == 6'd61) state_q <= S_DWB;
        end
        S_DWB: begin
          ratio_q <= (ca[63] ^ den[63]) ? ratio_n : q64;
          mop_q   <= M_REC;
          state_q <= S_MUL;
        end
        S_FIN: begin
          pop_c1_q  <= n1_q;
          pop_c11_q <= n11_q;
          pop_t_q   <= (nt_q <= {16'b0, floorv}) ? {16'b0, floorv} : nt_q;
          if (step_q != '1) step_q <= step_q + 32'd1;
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_c1_q    <= pop_c1_q;
            out_c11_q   <= pop_c11_q;
            out_t_q     <= pop_t_q;
            out_step_q  <= step_q;
            final_q     <= step_q >= end_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign in_stall_o    = state_q != S_IDLE;
  assign out_valid_o   = out_valid_q;
  assign size_c1_o     = out_c1_q;
  assign size_c11_o    = out_c11_q;
  assign size_tcells_o = out_t_q;
  assign step_number_o = out_step_q;
  assign final_res_o   = final_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("item taken while previous item still at work");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_EMIT))
    else $error("result raised outside emit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && step_q == '1) |=> step_q == '1)
    else $error("step count wrapped");

endmodule
`default_nettype wire
